### rtl/spsc_pkg.sv
// shared types, op codes and state encoding for the sorted pair sum counter
package spsc_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_START       = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] target;
    } spsc_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               overflowed;
    } spsc_rsp_t;

endpackage

### rtl/sorted_pair_sum_counter.sv
// top level of the sorted pair sum counter: load control, two-pointer walk and result register
//
//  channel | signals                          | transaction
//  req     | req_valid, req_ready, req_data   | load one element or start a walk
//  rsp     | rsp_valid, rsp_ready, rsp_data   | pair count and drop flag of one walk
//
// a start issues the first reads of the two store rams, then takes at most first
// length + second length walk steps, one step per read of the two stores, and then
// hands the result to the output register.
// no clearing pass after reset; read data is only compared below the loaded lengths.
// the finishing cycle waits while an earlier result is still untaken on rsp.
module sorted_pair_sum_counter
    import spsc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  spsc_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output spsc_rsp_t rsp_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] FULL = LW'(DEPTH);

    state_t state_reg, state_next;

    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          drop_reg, drop_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic signed [VALUE_W-1:0] target_reg;
    logic          flag_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    spsc_rsp_t     rsp_data_reg;

    logic req_fire, finish_fire, start_fire, start_ok, live;
    logic wr_a, wr_b;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [VALUE_W-1:0] rd_a, rd_b;
    logic signed [VALUE_W:0] sum, tgt_ext;
    logic sum_eq, sum_gt;
    logic [LW-1:0] j_less;

    spsc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (len_a_reg[AW-1:0]),
        .wr_data (req_data.value),
        .rd_addr (rd_addr_a),
        .rd_data (rd_a)
    );

    spsc_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (len_b_reg[AW-1:0]),
        .wr_data (req_data.value),
        .rd_addr (rd_addr_b),
        .rd_data (rd_b)
    );

    assign req_fire    = req_valid && req_ready;
    assign start_fire  = req_fire && (req_data.op == OP_START);
    assign start_ok    = (len_a_reg != '0) && (len_b_reg != '0);
    assign finish_fire = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    // sign-extended compare of the current pair against the target
    assign sum     = {rd_a[VALUE_W-1], rd_a} + {rd_b[VALUE_W-1], rd_b};
    assign tgt_ext = {target_reg[VALUE_W-1], target_reg};
    assign sum_eq  = (sum == tgt_ext);
    assign sum_gt  = (sum > tgt_ext);

    // load decode
    always_comb
    begin
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        drop_next  = drop_reg;
        if (req_fire)
        begin
            unique case (req_data.op)
                OP_LOAD_FIRST:
                begin
                    if (len_a_reg != FULL)
                    begin
                        wr_a       = 1'b1;
                        len_a_next = len_a_reg + LW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                OP_LOAD_SECOND:
                begin
                    if (len_b_reg != FULL)
                    begin
                        wr_b       = 1'b1;
                        len_b_next = len_b_reg + LW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (finish_fire)
        begin
            len_a_next = '0;
            len_b_next = '0;
            drop_next  = 1'b0;
        end
    end

    // walk pointers and read addresses
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        count_next = count_reg;
        if (state_reg == ST_IDLE)
        begin
            i_next     = '0;
            j_next     = len_b_reg;
            count_next = '0;
        end
        else if (state_reg == ST_WALK)
        begin
            i_next     = sum_gt ? i_reg : i_reg + LW'(1);
            j_next     = sum_gt ? j_reg - LW'(1) : j_reg;
            count_next = sum_eq ? count_reg + COUNT_W'(1) : count_reg;
        end
        j_less    = j_next - LW'(1);
        live      = (i_next < len_a_reg) && (j_next != '0);
        rd_addr_a = i_next[AW-1:0];
        rd_addr_b = j_less[AW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_fire)
                begin
                    state_next = start_ok ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK:
            begin
                if (!live)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        if (finish_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_fire)
        begin
            target_reg <= req_data.target;
            flag_reg   <= drop_reg;
        end
        if (finish_fire)
        begin
            rsp_data_reg.pair_count <= count_reg;
            rsp_data_reg.overflowed <= flag_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

### rtl/spsc_ram.sv
// generic single write port, single read port ram with registered read data
module spsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/spsc_checker.sv
// port-level assertions for the sorted pair sum counter, bound to the top level
module spsc_checker
    import spsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input spsc_req_t req_data,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input spsc_rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed or dropped while stalled");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.op == OP_START |=> !req_ready)
        else $error("request accepted during a walk");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.op != OP_START |=> req_ready)
        else $error("load transaction did not complete in one cycle");

    a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $rose(req_ready))
        else $error("result appeared outside the end of a walk");

endmodule

bind sorted_pair_sum_counter spsc_checker u_spsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
